>>> rtl/base64_encoder_line_wrap_core_defines.svh
// Assertion helpers used by the encoder's back end (b64lw_back).
// Each helper expects the including module to have clk and rst.
`ifndef BASE64_ENCODER_LINE_WRAP_CORE_DEFINES_SVH
`define BASE64_ENCODER_LINE_WRAP_CORE_DEFINES_SVH

// Same-cycle property, checked outside reset
`define B64LW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition this cycle implies a result on the next cycle
`define B64LW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/b64lw_pkg.sv
package b64lw_pkg;

  // Line length in characters when wrapping is on
  localparam int LINE_CHARS = 76;
  localparam int COL_W      = 7;

  // Queue depths (powers of two, pointers wrap naturally)
  localparam int REQ_DEPTH  = 2;
  localparam int REQ_PTR_W  = $clog2(REQ_DEPTH);
  localparam int REQ_CNT_W  = $clog2(REQ_DEPTH + 1);
  localparam int OUT_DEPTH  = 2;
  localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 1);

  // Most characters one byte can produce, pads included
  localparam int MAX_CHARS  = 4;
  localparam int CIDX_W     = $clog2(MAX_CHARS);

  localparam logic [7:0] CHAR_PAD = 8'h3D;
  localparam logic [7:0] CHAR_LF  = 8'h0A;

  // Position inside the current 3-byte group
  typedef enum logic [1:0] {
    GRP_FIRST  = 2'd0,
    GRP_SECOND = 2'd1,
    GRP_THIRD  = 2'd2
  } grp_pos_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } byte_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_of_run;
    logic       end_of_text;
  } char_item_t;

  // One request from front to back: the characters a byte produces
  typedef struct packed {
    logic [MAX_CHARS-1:0][7:0] chars;
    logic [CIDX_W-1:0]         last_idx;
    logic                      fin;
  } req_t;

  // Standard base64 alphabet
  function automatic logic [7:0] b64_char(input logic [5:0] code);
    logic [7:0] c8;
    c8 = {2'b00, code};
    if (code < 6'd26)      return 8'h41 + c8;
    else if (code < 6'd52) return 8'h61 + c8 - 8'd26;
    else if (code < 6'd62) return 8'h30 + c8 - 8'd52;
    else if (code == 6'd62) return 8'h2B;
    else                   return 8'h2F;
  endfunction

endpackage

>>> rtl/b64lw_front.sv
module b64lw_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  b64lw_pkg::byte_item_t byte_item,
  input  logic                  req_full,
  output logic                  req_push,
  output b64lw_pkg::req_t       req
);
  import b64lw_pkg::*;

  grp_pos_t   group_position, group_position_next;
  logic [3:0] held_bits, held_bits_next;
  logic [7:0] b;
  logic       fin;
  logic       accept;

  assign b        = byte_item.data_byte;
  assign fin      = byte_item.final_byte;
  assign accept   = push && !req_full;
  assign req_push = accept;

  // group state
  always_ff @(posedge clk) begin
    if (rst) begin
      group_position <= GRP_FIRST;
      held_bits      <= 4'd0;
    end else if (accept) begin
      group_position <= group_position_next;
      held_bits      <= held_bits_next;
    end
  end

  // classify the byte and build its characters
  always_comb begin
    req                 = '0;
    req.fin             = fin;
    group_position_next = group_position;
    held_bits_next      = held_bits;
    case (group_position)
      GRP_SECOND: begin
        req.chars[0]        = b64_char({held_bits[1:0], b[7:4]});
        held_bits_next      = b[3:0];
        group_position_next = GRP_THIRD;
        if (fin) begin
          req.chars[1] = b64_char({b[3:0], 2'b00});
          req.chars[2] = CHAR_PAD;
          req.last_idx = CIDX_W'(2);
        end
      end
      GRP_THIRD: begin
        req.chars[0]        = b64_char({held_bits, b[7:6]});
        req.chars[1]        = b64_char(b[5:0]);
        req.last_idx        = CIDX_W'(1);
        held_bits_next      = 4'd0;
        group_position_next = GRP_FIRST;
      end
      default: begin
        req.chars[0]        = b64_char(b[7:2]);
        held_bits_next      = {2'b00, b[1:0]};
        group_position_next = GRP_SECOND;
        if (fin) begin
          req.chars[1] = b64_char({b[1:0], 4'b0000});
          req.chars[2] = CHAR_PAD;
          req.chars[3] = CHAR_PAD;
          req.last_idx = CIDX_W'(3);
        end
      end
    endcase
    // message end restarts the group
    if (fin) begin
      group_position_next = GRP_FIRST;
      held_bits_next      = 4'd0;
    end
  end

endmodule

>>> rtl/b64lw_req_queue.sv
module b64lw_req_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  b64lw_pkg::req_t wr_req,
  output logic            full,
  input  logic            rd_en,
  output logic            valid,
  output b64lw_pkg::req_t rd_req
);
  import b64lw_pkg::*;

  req_t                 slots [REQ_DEPTH];
  logic [REQ_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [REQ_CNT_W-1:0] count;
  logic                 do_wr, do_rd;

  assign full   = (count == REQ_CNT_W'(REQ_DEPTH));
  assign valid  = (count != '0);
  assign rd_req = slots[rd_ptr];
  assign do_wr  = wr_en && !full;
  assign do_rd  = rd_en && valid;

  // payload slots
  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= wr_req;
  end

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + REQ_PTR_W'(1);
      if (do_rd) rd_ptr <= rd_ptr + REQ_PTR_W'(1);
      case ({do_wr, do_rd})
        2'b10:   count <= count + REQ_CNT_W'(1);
        2'b01:   count <= count - REQ_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/b64lw_back.sv
`include "base64_encoder_line_wrap_core_defines.svh"

module b64lw_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_wdata,
  input  logic                  req_valid,
  input  b64lw_pkg::req_t       req,
  output logic                  req_pop,
  output logic                  empty,
  input  logic                  pop,
  output b64lw_pkg::char_item_t char_item
);
  import b64lw_pkg::*;

  logic                 wrap_lines;
  logic [CIDX_W-1:0]    char_idx, char_idx_next;
  logic                 lf_pending, lf_pending_next;
  logic                 lf_is_last, lf_is_last_next;
  logic [COL_W-1:0]     line_column, line_column_next;
  logic [COL_W-1:0]     col_inc;
  logic                 is_last_char;
  logic                 emit;
  char_item_t           item;

  char_item_t           slots [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [OUT_CNT_W-1:0] out_count;
  logic                 out_full, do_rd;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) wrap_lines <= 1'b0;
    else if (cfg_we) wrap_lines <= cfg_wdata;
  end

  assign out_full     = (out_count == OUT_CNT_W'(OUT_DEPTH));
  assign emit         = req_valid && !out_full;
  assign col_inc      = line_column + COL_W'(1);
  assign is_last_char = (char_idx == req.last_idx);

  // one character or line feed per cycle while a request waits and the result queue has room
  always_comb begin
    item             = '0;
    char_idx_next    = char_idx;
    lf_pending_next  = lf_pending;
    lf_is_last_next  = lf_is_last;
    line_column_next = line_column;
    if (lf_pending) begin
      item.out_char    = CHAR_LF;
      item.last_of_run = lf_is_last;
      lf_pending_next  = 1'b0;
    end else begin
      item.out_char = req.chars[char_idx];
      char_idx_next = is_last_char ? '0 : char_idx + CIDX_W'(1);
      if (wrap_lines) begin
        line_column_next = col_inc;
        if (col_inc >= COL_W'(LINE_CHARS)) begin
          line_column_next = '0;
          lf_pending_next  = 1'b1;
          lf_is_last_next  = is_last_char;
        end
      end
      item.last_of_run = is_last_char && !lf_pending_next;
    end
    item.end_of_text = item.last_of_run && req.fin;
    // message end restarts the line
    if (item.end_of_text) line_column_next = '0;
  end

  assign req_pop = emit && item.last_of_run;

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      char_idx    <= '0;
      lf_pending  <= 1'b0;
      lf_is_last  <= 1'b0;
      line_column <= '0;
    end else if (emit) begin
      char_idx    <= char_idx_next;
      lf_pending  <= lf_pending_next;
      lf_is_last  <= lf_is_last_next;
      line_column <= line_column_next;
    end
  end

  // result queue: output register plus skid slot
  assign empty     = (out_count == '0);
  assign char_item = slots[rd_ptr];
  assign do_rd     = pop && !empty;

  always_ff @(posedge clk) begin
    if (emit) slots[wr_ptr] <= item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      out_count <= '0;
    end else begin
      if (emit)  wr_ptr <= wr_ptr + OUT_PTR_W'(1);
      if (do_rd) rd_ptr <= rd_ptr + OUT_PTR_W'(1);
      case ({emit, do_rd})
        2'b10:   out_count <= out_count + OUT_CNT_W'(1);
        2'b01:   out_count <= out_count - OUT_CNT_W'(1);
        default: out_count <= out_count;
      endcase
    end
  end

  // checks
  `B64LW_ASSERT(a_col_in_range, line_column < COL_W'(LINE_CHARS), "line column past line end")
  `B64LW_ASSERT(a_occ_bound, out_count <= OUT_CNT_W'(OUT_DEPTH), "result queue overfilled")
  `B64LW_ASSERT_NEXT(a_eot_col, emit && item.end_of_text, line_column == '0, "column not cleared at end")
  `B64LW_ASSERT_NEXT(a_lf_follows, emit && !lf_pending && lf_pending_next, lf_pending && char_idx == char_idx_next && req_valid, "line feed request lost")

endmodule

>>> rtl/base64_encoder_line_wrap_core.sv
// Streaming base64 encoder with optional line wrapping.
// Input channel: push/full carries byte_item (data_byte, final_byte); a byte is
// taken at a clock edge with push high and full low. Result channel: empty/pop
// carries char_item (out_char, last_of_run, end_of_text); the oldest character
// sits on char_item while empty is low and leaves on an edge with pop high.
// cfg_we/cfg_wdata write wrap_lines; write it only while no message is moving.
// With wrap_lines set, a line feed follows every 76th character.
// Each byte yields one or two characters; a final byte yields up to four with
// its pads, and up to five results when a line feed falls in. The back end
// issues one result per cycle while a request waits and the result queue has
// room, and it starts on the next request only after the last result of the
// current one.
// The first character of a byte passes through the request queue and then the
// result queue before it can be popped.
// A two-entry request queue parts front from back and a two-entry result queue
// parts back from the receiver: a stalled pop fills the result queue, then the
// request queue, and only then raises full.
// Synchronous reset clears group, column, queues and wrap_lines; empty is high.
module base64_encoder_line_wrap_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  b64lw_pkg::byte_item_t byte_item,
  output logic                  empty,
  input  logic                  pop,
  output b64lw_pkg::char_item_t char_item,
  input  logic                  cfg_we,
  input  logic                  cfg_wdata
);
  import b64lw_pkg::*;

  logic req_push, req_valid, req_pop;
  req_t req_in, req_out;

  b64lw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .byte_item (byte_item),
    .req_full  (full),
    .req_push  (req_push),
    .req       (req_in)
  );

  b64lw_req_queue u_req_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (req_push),
    .wr_req (req_in),
    .full   (full),
    .rd_en  (req_pop),
    .valid  (req_valid),
    .rd_req (req_out)
  );

  b64lw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req_valid (req_valid),
    .req       (req_out),
    .req_pop   (req_pop),
    .empty     (empty),
    .pop       (pop),
    .char_item (char_item)
  );

endmodule
